[rtl/core/spifba_pkg.sv]
// Shared types, codes and byte selection for the SPI FRAM byte access master.
package spifba_pkg;

  localparam int unsigned CodeWidth = 8;
  localparam int unsigned AddrWidth = 16;
  localparam logic [CodeWidth-1:0] WriteEnableCodeReset = 8'h06;
  localparam logic [CodeWidth-1:0] WriteCodeReset       = 8'h02;
  localparam logic [CodeWidth-1:0] ReadCodeReset        = 8'h03;

  localparam logic [2:0] WriteFinishStep = 3'd7;
  localparam logic [2:0] ReadFinishStep  = 3'd4;
  localparam logic [2:0] ReadRecvStep    = 3'd3;
  localparam logic [2:0] LastBit         = 3'd7;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_START_WRITE = 2'd1,
    OP_START_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_WRITE_ENABLE_CODE = 2'd0,
    REG_WRITE_CODE        = 2'd1,
    REG_READ_CODE         = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [CodeWidth-1:0] write_enable_code;
    logic [CodeWidth-1:0] write_code;
    logic [CodeWidth-1:0] read_code;
  } codes_t;

  typedef struct packed {
    mode_t                mode;
    logic [2:0]           byte_step;
    logic [2:0]           bit_step;
    logic                 clock_half;
    logic [7:0]           shift_out;
    logic [7:0]           shift_in;
    logic [AddrWidth-1:0] held_address;
    logic [7:0]           held_data;
    logic                 cs_n;
    logic                 sclk;
    logic                 mosi;
  } state_t;

  typedef struct packed {
    logic       chip_select_n;
    logic       serial_clock;
    logic       mosi;
    logic       busy_res;
    logic [7:0] read_data;
    logic       done_res;
    logic       rejected;
  } result_t;

  // Byte that goes on the wire at a given step of an access.
  function automatic logic [7:0] byte_for_step(mode_t mode, logic [2:0] step,
                                               codes_t codes,
                                               logic [AddrWidth-1:0] addr,
                                               logic [7:0] data);
    logic [7:0] b;
    b = 8'h00;
    unique case (mode)
      MODE_WRITE: begin
        case (step)
          3'd0:    b = codes.write_enable_code;
          3'd3:    b = codes.write_code;
          3'd4:    b = addr[15:8];
          3'd5:    b = addr[7:0];
          3'd6:    b = data;
          default: b = 8'h00;
        endcase
      end
      MODE_READ: begin
        case (step)
          3'd0:    b = codes.read_code;
          3'd1:    b = addr[15:8];
          3'd2:    b = addr[7:0];
          default: b = 8'h00;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/core/spifba_step.sv]
// Next-state and result logic for one beat of the SPI FRAM master.
module spifba_step (
  input  spifba_pkg::state_t   state,
  input  spifba_pkg::codes_t   codes,
  input  logic [1:0]           opcode,
  input  logic [15:0]          address,
  input  logic [7:0]           write_data,
  input  logic                 miso,
  output spifba_pkg::state_t   state_next,
  output spifba_pkg::result_t  result
);

  logic busy;
  logic wr;
  logic [2:0] finish;
  logic receive;
  logic done;
  logic rej;

  always_comb begin
    busy    = (state.mode == spifba_pkg::MODE_WRITE) ||
              (state.mode == spifba_pkg::MODE_READ);
    wr      = (state.mode == spifba_pkg::MODE_WRITE);
    finish  = wr ? spifba_pkg::WriteFinishStep : spifba_pkg::ReadFinishStep;
    receive = !wr && (state.byte_step == spifba_pkg::ReadRecvStep);
    state_next = state;
    done = 1'b0;
    rej  = 1'b0;

    if (opcode == spifba_pkg::OP_START_WRITE || opcode == spifba_pkg::OP_START_READ) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        state_next.mode = (opcode == spifba_pkg::OP_START_WRITE) ?
                          spifba_pkg::MODE_WRITE : spifba_pkg::MODE_READ;
        state_next.held_address = address;
        state_next.held_data    = write_data;
        state_next.byte_step    = 3'd0;
        state_next.bit_step     = 3'd0;
        state_next.clock_half   = 1'b0;
        state_next.shift_out    = spifba_pkg::byte_for_step(state_next.mode, 3'd0, codes,
                                                            address, write_data);
        state_next.cs_n = 1'b0;
        state_next.sclk = 1'b1;
      end
    end else if (opcode == spifba_pkg::OP_TICK && busy) begin
      if (state.byte_step >= finish) begin
        state_next.cs_n       = 1'b1;
        state_next.mode       = spifba_pkg::MODE_IDLE;
        state_next.byte_step  = 3'd0;
        state_next.bit_step   = 3'd0;
        state_next.clock_half = 1'b0;
        done = 1'b1;
      end else if (wr && state.byte_step == 3'd1) begin
        // select-high gap between enable and write commands
        state_next.cs_n      = 1'b1;
        state_next.byte_step = 3'd2;
      end else if (wr && state.byte_step == 3'd2) begin
        state_next.cs_n      = 1'b0;
        state_next.byte_step = 3'd3;
        state_next.shift_out = spifba_pkg::byte_for_step(state.mode, 3'd3, codes,
                                                         state.held_address, state.held_data);
      end else if (!state.clock_half) begin
        state_next.sclk = 1'b0;
        if (receive) begin
          state_next.shift_in = {state.shift_in[6:0], miso};
        end else begin
          state_next.mosi      = state.shift_out[7];
          state_next.shift_out = {state.shift_out[6:0], 1'b0};
        end
        state_next.clock_half = 1'b1;
      end else begin
        state_next.sclk       = 1'b1;
        state_next.clock_half = 1'b0;
        if (state.bit_step >= spifba_pkg::LastBit) begin
          state_next.bit_step  = 3'd0;
          state_next.byte_step = state.byte_step + 3'd1;
          state_next.shift_out = spifba_pkg::byte_for_step(state.mode, state.byte_step + 3'd1,
                                                           codes, state.held_address,
                                                           state.held_data);
        end else begin
          state_next.bit_step = state.bit_step + 3'd1;
        end
      end
    end

    if (rej) begin
      state_next = state;
    end

    result.chip_select_n = state_next.cs_n;
    result.serial_clock  = state_next.sclk;
    result.mosi          = state_next.mosi;
    result.busy_res      = (state_next.mode != spifba_pkg::MODE_IDLE);
    result.read_data     = state_next.shift_in;
    result.done_res      = done;
    result.rejected      = rej;
  end

endmodule

[rtl/core/spifba_out_reg.sv]
// Result register that parts the input side from a stalled receiver.
module spifba_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  spifba_pkg::result_t load_data,
  input  logic                out_stall,
  output logic                out_valid,
  output spifba_pkg::result_t out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

[rtl/core/spi_fram_byte_access_master_top.sv]
// Top level of the SPI FRAM byte access master.
//
// Usage: each input beat carries an opcode. A tick advances the serial link
// by one half bit (clock low with MOSI driven or MISO sampled, then clock
// high). A start write sends the write-enable command with select low,
// pulses select high, then sends write command, address high, address low
// and data. A start read sends read command and both address bytes, then
// shifts in one byte from MISO. A start while busy is rejected.
// Every accepted input beat yields exactly one output beat with the pin
// levels, busy, done, rejected and the byte read so far.
// The output beat is registered and valid in the cycle after the input beat is accepted.
// Throughput: one beat per cycle while in_stall is low; the state update for a beat is one pass
// through the step logic into the state register and the result register.
// Stall: in_stall rises only when the result register holds a beat that the
// receiver is stalling; the next input then waits until that beat leaves.
// Reset (rst, synchronous): idle, select and clock high, data low, command
// registers at their standard values, no output beat pending.
// Configuration writes via cfg_en/cfg_index/cfg_data take effect at once.
module spi_fram_byte_access_master_top #(
  parameter logic [7:0] WRITE_ENABLE_CODE_RESET = spifba_pkg::WriteEnableCodeReset,
  parameter logic [7:0] WRITE_CODE_RESET        = spifba_pkg::WriteCodeReset,
  parameter logic [7:0] READ_CODE_RESET         = spifba_pkg::ReadCodeReset
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [15:0] address,
  input  logic [7:0]  write_data,
  input  logic        miso,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        chip_select_n,
  output logic        serial_clock,
  output logic        mosi,
  output logic        busy_res,
  output logic [7:0]  read_data,
  output logic        done_res,
  output logic        rejected
);

  spifba_pkg::codes_t  codes;
  spifba_pkg::state_t  state;
  spifba_pkg::state_t  state_next;
  spifba_pkg::result_t step_result;
  spifba_pkg::result_t out_data;
  logic                in_accept;

  // command byte registers
  always_ff @(posedge clk) begin
    if (rst) begin
      codes.write_enable_code <= WRITE_ENABLE_CODE_RESET;
      codes.write_code        <= WRITE_CODE_RESET;
      codes.read_code         <= READ_CODE_RESET;
    end else if (cfg_en) begin
      case (cfg_index)
        spifba_pkg::REG_WRITE_ENABLE_CODE: codes.write_enable_code <= cfg_data;
        spifba_pkg::REG_WRITE_CODE:        codes.write_code        <= cfg_data;
        spifba_pkg::REG_READ_CODE:         codes.read_code         <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall only when the result register is full and being held
  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  spifba_step u_step (
    .state      (state),
    .codes      (codes),
    .opcode     (opcode),
    .address    (address),
    .write_data (write_data),
    .miso       (miso),
    .state_next (state_next),
    .result     (step_result)
  );

  // transaction state, pins included
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode         <= spifba_pkg::MODE_IDLE;
      state.byte_step    <= 3'd0;
      state.bit_step     <= 3'd0;
      state.clock_half   <= 1'b0;
      state.shift_out    <= 8'h00;
      state.shift_in     <= 8'h00;
      state.held_address <= 16'h0000;
      state.held_data    <= 8'h00;
      state.cs_n         <= 1'b1;
      state.sclk         <= 1'b1;
      state.mosi         <= 1'b0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  spifba_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .load_data (step_result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign chip_select_n = out_data.chip_select_n;
  assign serial_clock  = out_data.serial_clock;
  assign mosi          = out_data.mosi;
  assign busy_res      = out_data.busy_res;
  assign read_data     = out_data.read_data;
  assign done_res      = out_data.done_res;
  assign rejected      = out_data.rejected;

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && chip_select_n)
    else $error("done beat while still busy or selected");

  a_reject_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> busy_res && !done_res)
    else $error("reject outside a transaction");

  a_idle_pins: assert property (@(posedge clk) disable iff (rst)
    state.mode == spifba_pkg::MODE_IDLE |-> state.cs_n && state.sclk)
    else $error("idle with select or clock low");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted beat produced no result");
`endif

endmodule

[dv/tb_spi_fram_byte_access_master_top.sv]
// Self-checking testbench for the SPI FRAM byte access master top level.

class fram_access_scoreboard;
  spifba_pkg::codes_t     codes;
  spifba_pkg::mode_t      mode;
  logic [2:0]             byte_step;
  logic [2:0]             bit_step;
  logic                   clock_half;
  logic [7:0]             shift_out;
  logic [7:0]             shift_in;
  logic [15:0]            held_addr;
  logic [7:0]             held_data;
  logic                   cs_n;
  logic                   sclk;
  logic                   mosi_level;
  spifba_pkg::result_t    pin_beats_due[$];
  int unsigned            errors;

  function new();
    codes      = '{spifba_pkg::WriteEnableCodeReset, spifba_pkg::WriteCodeReset,
                   spifba_pkg::ReadCodeReset};
    mode       = spifba_pkg::MODE_IDLE;
    byte_step  = '0;
    bit_step   = '0;
    clock_half = 1'b0;
    shift_out  = '0;
    shift_in   = '0;
    held_addr  = '0;
    held_data  = '0;
    cs_n       = 1'b1;
    sclk       = 1'b1;
    mosi_level = 1'b0;
    errors     = 0;
  endfunction

  function void set_code(spifba_pkg::reg_index_t idx, logic [7:0] value);
    case (idx)
      spifba_pkg::REG_WRITE_ENABLE_CODE: codes.write_enable_code = value;
      spifba_pkg::REG_WRITE_CODE:        codes.write_code = value;
      spifba_pkg::REG_READ_CODE:         codes.read_code = value;
      default: ;
    endcase
  endfunction

  // Byte that goes out when a given step of the current access begins.
  function logic [7:0] wire_byte(logic [2:0] step);
    logic [7:0] b;
    b = 8'h00;
    if (mode == spifba_pkg::MODE_WRITE) begin
      case (step)
        3'd0: b = codes.write_enable_code;
        3'd3: b = codes.write_code;
        3'd4: b = held_addr[15:8];
        3'd5: b = held_addr[7:0];
        3'd6: b = held_data;
        default: b = 8'h00;
      endcase
    end else if (mode == spifba_pkg::MODE_READ) begin
      case (step)
        3'd0: b = codes.read_code;
        3'd1: b = held_addr[15:8];
        3'd2: b = held_addr[7:0];
        default: b = 8'h00;
      endcase
    end
    return b;
  endfunction

  // Advance the link by one accepted beat and queue the pin levels it yields.
  function void note_command(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                             logic miso_bit);
    spifba_pkg::result_t r;
    logic    busy;
    logic    done;
    logic    rej;
    logic    writing;
    busy = (mode != spifba_pkg::MODE_IDLE);
    done = 1'b0;
    rej  = 1'b0;
    if (op == spifba_pkg::OP_START_WRITE || op == spifba_pkg::OP_START_READ) begin
      if (busy) begin
        rej = 1'b1;
      end else begin
        mode       = (op == spifba_pkg::OP_START_WRITE) ? spifba_pkg::MODE_WRITE :
                                                          spifba_pkg::MODE_READ;
        held_addr  = addr;
        held_data  = data;
        byte_step  = '0;
        bit_step   = '0;
        clock_half = 1'b0;
        shift_out  = wire_byte(3'd0);
        cs_n       = 1'b0;
        sclk       = 1'b1;
      end
    end else if (op == spifba_pkg::OP_TICK && busy) begin
      writing = (mode == spifba_pkg::MODE_WRITE);
      if (byte_step >= (writing ? spifba_pkg::WriteFinishStep :
                                  spifba_pkg::ReadFinishStep)) begin
        cs_n       = 1'b1;
        mode       = spifba_pkg::MODE_IDLE;
        byte_step  = '0;
        bit_step   = '0;
        clock_half = 1'b0;
        done       = 1'b1;
      end else if (writing && byte_step == 3'd1) begin
        cs_n      = 1'b1;
        byte_step = 3'd2;
      end else if (writing && byte_step == 3'd2) begin
        cs_n      = 1'b0;
        byte_step = 3'd3;
        shift_out = wire_byte(3'd3);
      end else if (!clock_half) begin
        sclk = 1'b0;
        if (!writing && byte_step == spifba_pkg::ReadRecvStep) begin
          shift_in = {shift_in[6:0], miso_bit};
        end else begin
          mosi_level = shift_out[7];
          shift_out  = {shift_out[6:0], 1'b0};
        end
        clock_half = 1'b1;
      end else begin
        sclk       = 1'b1;
        clock_half = 1'b0;
        if (bit_step == spifba_pkg::LastBit) begin
          bit_step  = '0;
          byte_step = byte_step + 3'd1;
          shift_out = wire_byte(byte_step);
        end else begin
          bit_step = bit_step + 3'd1;
        end
      end
    end
    r.chip_select_n = cs_n;
    r.serial_clock  = sclk;
    r.mosi          = mosi_level;
    r.busy_res      = (mode != spifba_pkg::MODE_IDLE);
    r.read_data     = shift_in;
    r.done_res      = done;
    r.rejected      = rej;
    pin_beats_due.push_back(r);
  endfunction

  function void compare_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_beat(spifba_pkg::result_t got);
    spifba_pkg::result_t want;
    if (pin_beats_due.size() == 0) begin
      $error("output beat with nothing expected");
      errors++;
      return;
    end
    want = pin_beats_due.pop_front();
    compare_field("chip_select_n", want.chip_select_n, got.chip_select_n);
    compare_field("serial_clock", want.serial_clock, got.serial_clock);
    compare_field("mosi", want.mosi, got.mosi);
    compare_field("busy_res", want.busy_res, got.busy_res);
    compare_field("read_data", want.read_data, got.read_data);
    compare_field("done_res", want.done_res, got.done_res);
    compare_field("rejected", want.rejected, got.rejected);
  endfunction
endclass

module tb_spi_fram_byte_access_master_top;
  timeunit 1ns;
  timeprecision 1ps;

  // opcode value the block must ignore
  localparam logic [1:0] OpUnused = 2'd3;
  // cycles with no beat on either side before the run is declared hung
  localparam int unsigned QuietLimit = 2000;
  // length of the one long receiver hold-off
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ItemsPerPhase = 285;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = '0;
  logic [15:0] address = '0;
  logic [7:0]  write_data = '0;
  logic        miso = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        chip_select_n;
  logic        serial_clock;
  logic        mosi;
  logic        busy_res;
  logic [7:0]  read_data;
  logic        done_res;
  logic        rejected;

  fram_access_scoreboard sb;

  int unsigned tx_idle_pct = 0;   // only touched by the stimulus process
  int unsigned rx_idle_pct = 0;   // set by NBA, read by the receiver
  logic        press_req = 1'b0;  // asks the receiver for the long hold-off
  logic        press_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sent_items = 0;

  spi_fram_byte_access_master_top dut (
    .clk(clk), .rst(rst),
    .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .address(address), .write_data(write_data), .miso(miso),
    .out_valid(out_valid), .out_stall(out_stall),
    .chip_select_n(chip_select_n), .serial_clock(serial_clock), .mosi(mosi),
    .busy_res(busy_res), .read_data(read_data), .done_res(done_res),
    .rejected(rejected)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver: random stalls, plus one long hold-off when asked. During the
  // hold-off the sender keeps offering, so the result register fills and
  // in_stall has to rise.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (press_req && !press_done) begin
      hold_left  <= HoldCycles;
      press_done <= 1'b1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Output monitor: values seen here are the ones from before the edge.
  always @(posedge clk) begin : monitor
    spifba_pkg::result_t got;
    if (!rst && out_valid && !out_stall) begin
      got = {chip_select_n, serial_clock, mosi, busy_res, read_data, done_res, rejected};
      sb.check_beat(got);
    end
  end

  // Watchdog: a long run of cycles with no beat on either side means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one beat, with random gaps ahead of it, and wait for acceptance.
  task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [7:0] data,
                           logic miso_bit);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    address    <= addr;
    write_data <= data;
    miso       <= miso_bit;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_command(op, addr, data, miso_bit);
    if (op != OpUnused) sent_items++;
  endtask

  // Stop offering and wait until every expected beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pin_beats_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_codes(logic [7:0] we_code, logic [7:0] wr_code,
                               logic [7:0] rd_code);
    spifba_pkg::reg_index_t  idx;
    logic [7:0]  vals [3];
    vals[0] = we_code;
    vals[1] = wr_code;
    vals[2] = rd_code;
    for (int i = 0; i < 3; i++) begin
      idx       = spifba_pkg::reg_index_t'(i);
      cfg_en    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_code(idx, vals[i]);
    end
    cfg_en <= 1'b0;
  endtask

  // Addresses and data lean on the extremes now and then.
  function automatic logic [15:0] pick_addr();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  // One access: mostly a clean start followed by ticks until done, with the
  // odd stray start or unused opcode mixed in; sometimes pure noise.
  task automatic run_transfer();
    int unsigned roll;
    logic [1:0]  op;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      repeat ($urandom_range(1, 8)) begin
        op = 2'($urandom_range(0, 3));
        send_item(op, pick_addr(), pick_byte(), 1'($urandom()));
      end
    end else begin
      op = (roll < 6) ? spifba_pkg::OP_START_WRITE : spifba_pkg::OP_START_READ;
      send_item(op, pick_addr(), pick_byte(), 1'($urandom()));
      while (sb.mode != spifba_pkg::MODE_IDLE) begin
        case ($urandom_range(0, 39))
          0: send_item(spifba_pkg::OP_START_WRITE, pick_addr(), pick_byte(),
                       1'($urandom()));
          1: send_item(spifba_pkg::OP_START_READ, pick_addr(), pick_byte(),
                       1'($urandom()));
          2: send_item(OpUnused, pick_addr(), pick_byte(), 1'($urandom()));
          default: send_item(spifba_pkg::OP_TICK, pick_addr(), pick_byte(),
                             1'($urandom()));
        endcase
      end
      // a tick on an idle link now and then
      if ($urandom_range(0, 3) == 0)
        send_item(spifba_pkg::OP_TICK, pick_addr(), pick_byte(), 1'($urandom()));
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, with the codes left at their reset values: idle tick,
    // unused opcode while idle, a write start at the top address, then
    // starts and the unused opcode while busy. The write stays open across
    // the next code update, which writes the reset values again.
    tx_idle_pct = 13;
    rx_idle_pct <= 74;
    send_item(spifba_pkg::OP_TICK, 16'hFFFF, 8'hFF, 1'b1);
    send_item(OpUnused, 16'hFFFF, 8'hFF, 1'b1);
    send_item(spifba_pkg::OP_START_WRITE, 16'hFFFF, 8'h00, 1'b0);
    send_item(spifba_pkg::OP_START_WRITE, 16'h0000, 8'hFF, 1'b1);
    send_item(spifba_pkg::OP_START_READ, 16'h0000, 8'hFF, 1'b1);
    send_item(OpUnused, 16'h0000, 8'h00, 1'b0);
    send_item(spifba_pkg::OP_TICK, 16'h0000, 8'h00, 1'b0);
    send_item(spifba_pkg::OP_TICK, 16'hFFFF, 8'hFF, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: program_codes(spifba_pkg::WriteEnableCodeReset, spifba_pkg::WriteCodeReset,
                         spifba_pkg::ReadCodeReset);
        1: program_codes(8'hFF, 8'hFF, 8'hFF);
        2: program_codes(8'h00, 8'h00, 8'h00);
        default: program_codes(8'($urandom()), 8'($urandom()), 8'($urandom()));
      endcase
      // sender light / receiver heavy, then swapped, then no idling at all
      case (phase)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct <= 74;
        end
        1: begin
          tx_idle_pct = 74;
          rx_idle_pct <= 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      if (phase == 2) press_req <= 1'b1;
      while (sent_items < (phase + 1) * ItemsPerPhase) run_transfer();
    end

    in_valid <= 1'b0;
    while (sb.pin_beats_due.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.pin_beats_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
